// ===== sv/ism_pkg.sv =====
// Shared types and codes for the integer stack machine.
// Used by ism_ctrl, ism_datapath and integer_stack_machine; depends on nothing.
package ism_pkg;

  localparam int STACK_DEPTH_DEFAULT = 32;

  // Instruction codes on the command port
  localparam logic [2:0] CMD_PUSH = 3'd0;
  localparam logic [2:0] CMD_ADD  = 3'd1;
  localparam logic [2:0] CMD_MUL  = 3'd2;
  localparam logic [2:0] CMD_DUP  = 3'd3;
  localparam logic [2:0] CMD_DUMP = 3'd4;

  // Result kinds
  localparam logic [1:0] KIND_STEP  = 2'd0;
  localparam logic [1:0] KIND_COUNT = 2'd1;
  localparam logic [1:0] KIND_ENTRY = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [1:0] ST_REFUSED   = 2'd3;

  // Datapath operations issued by the controller
  localparam logic [3:0] OP_IDLE       = 4'd0;
  localparam logic [3:0] OP_PUSH_IMM   = 4'd1;
  localparam logic [3:0] OP_PUSH_TOS   = 4'd2;
  localparam logic [3:0] OP_FAULT      = 4'd3;
  localparam logic [3:0] OP_NOP        = 4'd4;
  localparam logic [3:0] OP_REFUSE     = 4'd5;
  localparam logic [3:0] OP_FETCH      = 4'd6;
  localparam logic [3:0] OP_ADD        = 4'd7;
  localparam logic [3:0] OP_MUL        = 4'd8;
  localparam logic [3:0] OP_DUMP_HEAD  = 4'd9;
  localparam logic [3:0] OP_DUMP_ENTRY = 4'd10;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] status;   // error code for OP_FAULT
  } ctrl_t;

  typedef struct packed {
    logic empty;
    logic lt2;
    logic full;
    logic err;
    logic walk_done;
  } stat_t;

endpackage

// ===== sv/ism_ctrl.sv =====
// Controller of the integer stack machine: decodes words and sequences the datapath.
// Depends on ism_pkg.
module ism_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [2:0]        command,
  input  ism_pkg::stat_t    stat,
  output ism_pkg::ctrl_t    ctrl,
  output logic              busy
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DUMP = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       mul_sel;
  logic       mul_sel_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next   = state;
    mul_sel_next = mul_sel;
    ctrl.op      = ism_pkg::OP_IDLE;
    ctrl.status  = ism_pkg::ST_OK;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (stat.err) begin
            ctrl.op = ism_pkg::OP_REFUSE;
          end else begin
            case (command)
              ism_pkg::CMD_PUSH: begin
                if (stat.full) begin
                  ctrl.op     = ism_pkg::OP_FAULT;
                  ctrl.status = ism_pkg::ST_OVERFLOW;
                end else begin
                  ctrl.op = ism_pkg::OP_PUSH_IMM;
                end
              end
              ism_pkg::CMD_DUP: begin
                if (stat.empty) begin
                  ctrl.op     = ism_pkg::OP_FAULT;
                  ctrl.status = ism_pkg::ST_UNDERFLOW;
                end else if (stat.full) begin
                  ctrl.op     = ism_pkg::OP_FAULT;
                  ctrl.status = ism_pkg::ST_OVERFLOW;
                end else begin
                  ctrl.op = ism_pkg::OP_PUSH_TOS;
                end
              end
              ism_pkg::CMD_ADD, ism_pkg::CMD_MUL: begin
                if (stat.lt2) begin
                  ctrl.op     = ism_pkg::OP_FAULT;
                  ctrl.status = ism_pkg::ST_UNDERFLOW;
                end else begin
                  // fetch the second operand, combine next cycle
                  ctrl.op      = ism_pkg::OP_FETCH;
                  mul_sel_next = (command == ism_pkg::CMD_MUL);
                  state_next   = S_EXEC;
                end
              end
              ism_pkg::CMD_DUMP: begin
                ctrl.op = ism_pkg::OP_DUMP_HEAD;
                if (!stat.empty) begin
                  state_next = S_DUMP;
                end
              end
              default: begin
                ctrl.op = ism_pkg::OP_NOP;
              end
            endcase
          end
        end
      end
      S_EXEC: begin
        ctrl.op    = mul_sel ? ism_pkg::OP_MUL : ism_pkg::OP_ADD;
        state_next = S_IDLE;
      end
      S_DUMP: begin
        ctrl.op = ism_pkg::OP_DUMP_ENTRY;
        if (stat.walk_done) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    mul_sel <= mul_sel_next;
  end

endmodule

// ===== sv/ism_datapath.sv =====
// Datapath of the integer stack machine: stack memory, top register, counters, result register.
// Depends on ism_pkg.
module ism_datapath #(
  parameter int STACK_DEPTH = ism_pkg::STACK_DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ism_pkg::ctrl_t        ctrl,
  input  logic [31:0]           imm,
  output ism_pkg::stat_t        stat,
  output logic                  strobe,
  output logic [1:0]            kind,
  output logic [1:0]            status,
  output logic [15:0]           line_number,
  output logic [31:0]           data,
  output logic                  last
);

  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int AW  = $clog2(STACK_DEPTH);

  logic [31:0]    mem [STACK_DEPTH];
  logic [31:0]    rd_data;
  logic [AW-1:0]  rd_addr;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [31:0]    wr_data;

  logic [SPW-1:0] sp;
  logic [SPW-1:0] sp_m1;
  logic [SPW-1:0] sp_m2;
  logic [31:0]    tos;
  logic [AW-1:0]  walk;
  logic [15:0]    count;
  logic [15:0]    line_next;
  logic [1:0]     err;
  logic [15:0]    err_line;

  logic [31:0]    top_now;
  logic [31:0]    push_val;
  logic [31:0]    alu_r;
  logic           emit;
  logic [1:0]     o_kind;
  logic [1:0]     o_status;
  logic [15:0]    o_line;
  logic [31:0]    o_data;
  logic           o_last;

  assign sp_m1     = sp - SPW'(1);
  assign sp_m2     = sp - SPW'(2);
  assign line_next = (count == 16'hFFFF) ? count : count + 16'd1;
  assign top_now   = (sp == '0) ? 32'd0 : tos;
  assign push_val  = (ctrl.op == ism_pkg::OP_PUSH_TOS) ? tos : imm;
  // top entry lives in tos, second entry arrives from memory
  assign alu_r     = (ctrl.op == ism_pkg::OP_MUL) ? tos * rd_data : tos + rd_data;

  assign stat.empty     = (sp == '0);
  assign stat.lt2       = (sp < SPW'(2));
  assign stat.full      = (sp == SPW'(STACK_DEPTH));
  assign stat.err       = (err != ism_pkg::ST_OK);
  assign stat.walk_done = (walk == '0);

  // Memory ports
  always_comb begin
    case (ctrl.op)
      ism_pkg::OP_FETCH:     rd_addr = sp_m2[AW-1:0];
      ism_pkg::OP_DUMP_HEAD: rd_addr = sp_m1[AW-1:0];
      default:               rd_addr = walk - AW'(1);
    endcase
    wr_en   = 1'b0;
    wr_addr = sp[AW-1:0];
    wr_data = push_val;
    case (ctrl.op)
      ism_pkg::OP_PUSH_IMM, ism_pkg::OP_PUSH_TOS: begin
        wr_en = 1'b1;
      end
      ism_pkg::OP_ADD, ism_pkg::OP_MUL: begin
        wr_en   = 1'b1;
        wr_addr = sp_m2[AW-1:0];
        wr_data = alu_r;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Result word
  always_comb begin
    emit     = 1'b0;
    o_kind   = ism_pkg::KIND_STEP;
    o_status = ism_pkg::ST_OK;
    o_line   = line_next;
    o_data   = top_now;
    o_last   = 1'b1;
    case (ctrl.op)
      ism_pkg::OP_PUSH_IMM, ism_pkg::OP_PUSH_TOS: begin
        emit   = 1'b1;
        o_data = push_val;
      end
      ism_pkg::OP_FAULT: begin
        emit     = 1'b1;
        o_status = ctrl.status;
      end
      ism_pkg::OP_NOP: begin
        emit = 1'b1;
      end
      ism_pkg::OP_REFUSE: begin
        emit     = 1'b1;
        o_status = ism_pkg::ST_REFUSED;
        o_line   = err_line;
      end
      ism_pkg::OP_ADD, ism_pkg::OP_MUL: begin
        emit   = 1'b1;
        o_line = count;
        o_data = alu_r;
      end
      ism_pkg::OP_DUMP_HEAD: begin
        emit   = 1'b1;
        o_kind = ism_pkg::KIND_COUNT;
        o_line = count;
        o_data = 32'(sp);
        o_last = (sp == '0);
      end
      ism_pkg::OP_DUMP_ENTRY: begin
        emit   = 1'b1;
        o_kind = ism_pkg::KIND_ENTRY;
        o_line = count;
        o_data = rd_data;
        o_last = (walk == '0);
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe   <= 1'b0;
      sp       <= '0;
      count    <= '0;
      err      <= ism_pkg::ST_OK;
      err_line <= '0;
    end else begin
      strobe <= emit;
      case (ctrl.op)
        ism_pkg::OP_PUSH_IMM, ism_pkg::OP_PUSH_TOS: begin
          count <= line_next;
          sp    <= sp + SPW'(1);
        end
        ism_pkg::OP_FAULT: begin
          count    <= line_next;
          err      <= ctrl.status;
          err_line <= line_next;
        end
        ism_pkg::OP_NOP, ism_pkg::OP_FETCH: begin
          count <= line_next;
        end
        ism_pkg::OP_ADD, ism_pkg::OP_MUL: begin
          sp <= sp_m1;
        end
        ism_pkg::OP_DUMP_HEAD: begin
          if (sp == '0) begin
            count    <= '0;
            err      <= ism_pkg::ST_OK;
            err_line <= '0;
          end
        end
        ism_pkg::OP_DUMP_ENTRY: begin
          // drop the whole program once the bottom entry is out
          if (walk == '0) begin
            sp       <= '0;
            count    <= '0;
            err      <= ism_pkg::ST_OK;
            err_line <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (emit) begin
      kind        <= o_kind;
      status      <= o_status;
      line_number <= o_line;
      data        <= o_data;
      last        <= o_last;
    end
    case (ctrl.op)
      ism_pkg::OP_PUSH_IMM, ism_pkg::OP_PUSH_TOS: tos <= push_val;
      ism_pkg::OP_ADD, ism_pkg::OP_MUL:           tos <= alu_r;
      default:                                    tos <= tos;
    endcase
    case (ctrl.op)
      ism_pkg::OP_DUMP_HEAD:  walk <= sp_m1[AW-1:0];
      ism_pkg::OP_DUMP_ENTRY: walk <= walk - AW'(1);
      default:                walk <= walk;
    endcase
  end

endmodule

// ===== sv/integer_stack_machine.sv =====
// Integer stack machine: push, dup and status-only words give a registered result in the cycle
// after accept with busy low, so one word per cycle; add and multiply hold busy while the
// second operand is read from the stack memory, and their result is registered after the combine.
// Dump gives the count in the cycle after accept, then one entry per cycle through the same read
// port, busy until the bottom entry is out. The receiver cannot stall results.
// Reset (rst, synchronous) empties the stack and clears counter and error; memory is not swept.
module integer_stack_machine #(
  parameter int STACK_DEPTH = ism_pkg::STACK_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         command,
  input  logic signed [31:0] immediate,
  output logic               strobe,
  output logic [1:0]         kind,
  output logic [1:0]         status,
  output logic [15:0]        line_number,
  output logic signed [31:0] data,
  output logic               last
);

  // Controller decides per word; datapath holds stack, counters and the result register.
  ism_pkg::ctrl_t ctrl;
  ism_pkg::stat_t stat;
  logic [31:0]    data_u;

  ism_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .stat    (stat),
    .ctrl    (ctrl),
    .busy    (busy)
  );

  ism_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .imm         ($unsigned(immediate)),
    .stat        (stat),
    .strobe      (strobe),
    .kind        (kind),
    .status      (status),
    .line_number (line_number),
    .data        (data_u),
    .last        (last)
  );

  assign data = $signed(data_u);

`ifndef SYNTHESIS
  // A push taken while idle always reports in the next cycle.
  a_push_reports: assert property (@(posedge clk) disable iff (rst)
    start && !busy && command == ism_pkg::CMD_PUSH |=> strobe)
    else $error("push word gave no result");

  // Step results are single words, so they always close their item.
  a_step_last: assert property (@(posedge clk) disable iff (rst)
    strobe && kind == ism_pkg::KIND_STEP |-> last)
    else $error("step result without last");

  // Dump words never carry an error status.
  a_dump_ok: assert property (@(posedge clk) disable iff (rst)
    strobe && (kind == ism_pkg::KIND_COUNT || kind == ism_pkg::KIND_ENTRY)
      |-> status == ism_pkg::ST_OK)
    else $error("dump result with error status");

  // A fresh fault leaves the controller idle.
  a_fault_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && (status == ism_pkg::ST_UNDERFLOW || status == ism_pkg::ST_OVERFLOW) |-> !busy)
    else $error("busy while reporting a fault");
`endif

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for integer_stack_machine: random and directed instruction words,
// checked result by result against a behavioral stack predictor kept in a scoreboard class.
// Depends on ism_pkg and integer_stack_machine only.
`timescale 1ns / 1ps

module tb;

  localparam int DEPTH          = ism_pkg::STACK_DEPTH_DEFAULT;
  localparam int RANDOM_WORDS   = 420;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int MAX_REPORTS    = 10;

  // Command codes with no defined operation: the block counts them and moves on
  localparam logic [2:0] CMD_UNKNOWN_LO = 3'd5;
  localparam logic [2:0] CMD_UNKNOWN_HI = 3'd7;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [15:0] line;
    logic [31:0] data;
    logic        last;
  } result_word_t;

  // Scoreboard: runs every accepted instruction word through its own copy of the stack,
  // queues the result words it should cause, and matches them against the strobed ones.
  class stack_result_board;
    logic [31:0]  cells [DEPTH];
    int unsigned  depth;
    logic [15:0]  line_count;
    logic [1:0]   fault;
    logic [15:0]  fault_line;
    result_word_t due [$];
    int unsigned  mismatches;
    int unsigned  checked;

    function new();
      clear();
      mismatches = 0;
      checked    = 0;
    endfunction

    // Return to the empty program; stack cells keep stale contents like the memory
    function void clear();
      depth      = 0;
      line_count = '0;
      fault      = ism_pkg::ST_OK;
      fault_line = '0;
    endfunction

    function logic [31:0] top_cell();
      return (depth == 0) ? 32'd0 : cells[depth-1];
    endfunction

    function void queue_result(logic [1:0] kind, logic [1:0] status, logic [15:0] line,
                               logic [31:0] data, logic last);
      result_word_t w;
      w.kind   = kind;
      w.status = status;
      w.line   = line;
      w.data   = data;
      w.last   = last;
      due = {due, w};
    endfunction

    function void issue_word(logic [2:0] cmd, logic [31:0] imm);
      logic [1:0]  verdict;
      int unsigned i;
      // Sticky error: everything, dump included, is refused and leaves state alone
      if (fault != ism_pkg::ST_OK) begin
        queue_result(ism_pkg::KIND_STEP, ism_pkg::ST_REFUSED, fault_line, top_cell(), 1'b1);
        return;
      end
      // Dump: count first, then entries top down; not counted as an instruction
      if (cmd == ism_pkg::CMD_DUMP) begin
        queue_result(ism_pkg::KIND_COUNT, ism_pkg::ST_OK, line_count, 32'(depth),
                     depth == 0);
        for (i = depth; i > 0; i--)
          queue_result(ism_pkg::KIND_ENTRY, ism_pkg::ST_OK, line_count, cells[i-1], i == 1);
        clear();
        return;
      end
      if (line_count != 16'hFFFF)
        line_count++;
      verdict = ism_pkg::ST_OK;
      case (cmd)
        ism_pkg::CMD_PUSH: begin
          if (depth >= DEPTH) begin
            verdict = ism_pkg::ST_OVERFLOW;
          end else begin
            cells[depth] = imm;
            depth++;
          end
        end
        ism_pkg::CMD_ADD, ism_pkg::CMD_MUL: begin
          if (depth < 2) begin
            verdict = ism_pkg::ST_UNDERFLOW;
          end else begin
            cells[depth-2] = (cmd == ism_pkg::CMD_ADD) ? cells[depth-1] + cells[depth-2]
                                                       : cells[depth-1] * cells[depth-2];
            depth--;
          end
        end
        ism_pkg::CMD_DUP: begin
          if (depth == 0) begin
            verdict = ism_pkg::ST_UNDERFLOW;
          end else if (depth >= DEPTH) begin
            verdict = ism_pkg::ST_OVERFLOW;
          end else begin
            cells[depth] = cells[depth-1];
            depth++;
          end
        end
        default: ;
      endcase
      if (verdict != ism_pkg::ST_OK) begin
        fault      = verdict;
        fault_line = line_count;
      end
      queue_result(ism_pkg::KIND_STEP, verdict, line_count, top_cell(), 1'b1);
    endfunction

    function void check_result(logic [1:0] kind, logic [1:0] status, logic [15:0] line,
                               logic [31:0] data, logic last);
      result_word_t want;
      if (due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with nothing pending: kind=%0d status=%0d line=%0d data=%h last=%0b",
                   $realtime, kind, status, line, data, last);
        return;
      end
      want = due.pop_front();
      checked++;
      if (kind !== want.kind || status !== want.status || line !== want.line ||
          data !== want.data || last !== want.last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: result %0d mismatch", $realtime, checked);
          $display("  expected kind=%0d status=%0d line=%0d data=%h last=%0b",
                   want.kind, want.status, want.line, want.data, want.last);
          $display("  actual   kind=%0d status=%0d line=%0d data=%h last=%0b",
                   kind, status, line, data, last);
        end
      end
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [2:0]         command;
  logic signed [31:0] immediate;
  logic               strobe;
  logic [1:0]         kind;
  logic [1:0]         status;
  logic [15:0]        line_number;
  logic signed [31:0] data;
  logic               last;

  stack_result_board sb = new();

  int    cycle_count = 0;
  int    words_sent  = 0;
  int    burst_left  = 0;
  int    stack_level = 0;   // stack depth as the sender tracks it
  int    dumps       = 0;
  int    deepest     = 0;
  string fault_case  = "none";

  integer_stack_machine uut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .command     (command),
    .immediate   (immediate),
    .strobe      (strobe),
    .kind        (kind),
    .status      (status),
    .line_number (line_number),
    .data        (data),
    .last        (last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watch both sides at the clock edge: an input word is taken when start is high and busy
  // low, a result word exists for exactly the cycle its strobe is high.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy)
        sb.issue_word(command, immediate);
      if (strobe)
        sb.check_result(kind, status, line_number, data, last);
    end
  end

  // Watchdog: give up well past the slowest legal run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results pending", cycle_count, sb.pending());
      $display("tb NOT OK");
      $finish;
    end
  end

  // Send one instruction word. The sender runs in bursts: when a burst is used up, drop
  // start for a random gap (with junk on the payload) and pick the next burst length,
  // sometimes long so that back-to-back words also get through. Hold the word until the
  // block takes it.
  task automatic send_word(input logic [2:0] cmd, input logic [31:0] imm);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      start     <= 1'b0;
      command   <= 3'($urandom());
      immediate <= $urandom();
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
    end
    burst_left--;
    start     <= 1'b1;
    command   <= cmd;
    immediate <= imm;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent++;
  endtask

  // Pause the sender until every expected result word has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  // Push values lean on the corners of the 32-bit range now and then
  function automatic logic [31:0] pick_imm();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'h8000_0000;
      4:       return 32'($urandom_range(0, 15));
      default: return $urandom();
    endcase
  endfunction

  // Choose a legal next instruction for the current depth; grow_only keeps it filling
  function automatic logic [2:0] pick_op(input bit grow_only);
    int r;
    r = $urandom_range(0, 99);
    if (r < 5)
      return 3'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI));
    if (stack_level == 0)
      return ism_pkg::CMD_PUSH;
    if (stack_level >= DEPTH)
      return (r < 50) ? ism_pkg::CMD_ADD : ism_pkg::CMD_MUL;
    if (grow_only)
      return (r < 70) ? ism_pkg::CMD_PUSH : ism_pkg::CMD_DUP;
    if (stack_level < 2 || r < 40)
      return ism_pkg::CMD_PUSH;
    if (r < 55)
      return ism_pkg::CMD_DUP;
    if (r < 80)
      return ism_pkg::CMD_ADD;
    return ism_pkg::CMD_MUL;
  endfunction

  task automatic push_value(input logic [31:0] imm);
    send_word(ism_pkg::CMD_PUSH, imm);
    stack_level++;
    if (stack_level > deepest) deepest = stack_level;
  endtask

  // Send one instruction and advance the sender's view of the depth
  task automatic step(input logic [2:0] cmd);
    if (cmd == ism_pkg::CMD_PUSH) begin
      push_value(pick_imm());
    end else begin
      send_word(cmd, $urandom());
      case (cmd)
        ism_pkg::CMD_DUP: begin
          stack_level++;
          if (stack_level > deepest) deepest = stack_level;
        end
        ism_pkg::CMD_ADD, ism_pkg::CMD_MUL: stack_level--;
        ism_pkg::CMD_DUMP: begin
          stack_level = 0;
          dumps++;
        end
        default: ;
      endcase
    end
  endtask

  task automatic fill_stack();
    while (stack_level < DEPTH) step(pick_op(1'b1));
  endtask

  // One well-formed program ending in a dump. Most stay shallow; about one in eight first
  // fills the stack to the top so that the long dump walks get exercised.
  task automatic run_program();
    int  len;
    bit  go_full;
    go_full = ($urandom_range(0, 7) == 0);
    len     = $urandom_range(1, 30);
    if (go_full) fill_stack();
    repeat (len) step(pick_op(1'b0));
    if (go_full && $urandom_range(0, 1) == 0) fill_stack();
    step(ism_pkg::CMD_DUMP);
  endtask

  initial begin
    int directed_words;
    rst       = 1'b1;
    start     = 1'b0;
    command   = ism_pkg::CMD_PUSH;
    immediate = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: wrapping add and multiply at the range limits, every operation,
    // the unknown codes, dump of a four-entry, an empty and a one-entry stack.
    push_value(32'h7FFF_FFFF);
    push_value(32'h0000_0001);
    step(ism_pkg::CMD_ADD);
    push_value(32'h8000_0000);
    step(ism_pkg::CMD_MUL);
    push_value(32'hFFFF_FFFF);
    step(ism_pkg::CMD_DUP);
    step(ism_pkg::CMD_MUL);
    push_value(32'h5555_5555);
    push_value(32'hAAAA_AAAA);
    step(ism_pkg::CMD_ADD);
    step(CMD_UNKNOWN_LO);
    step(CMD_UNKNOWN_LO + 3'd1);
    step(CMD_UNKNOWN_HI);
    push_value(32'h0000_0000);
    step(ism_pkg::CMD_DUMP);
    step(ism_pkg::CMD_DUMP);
    push_value(32'hFFFF_FFFF);
    step(ism_pkg::CMD_DUMP);
    directed_words = words_sent;

    // Random programs, now and then letting the block run dry first
    while (words_sent < directed_words + RANDOM_WORDS) begin
      run_program();
      if ($urandom_range(0, 9) == 0) drain();
    end
    drain();

    // Errors are sticky and reset comes only once, so close with a single error case,
    // then confirm that every later word, dump included, is refused.
    case ($urandom_range(0, 4))
      0: begin
        fault_case = "add with one entry";
        push_value(pick_imm());
        send_word(ism_pkg::CMD_ADD, $urandom());
      end
      1: begin
        fault_case = "multiply on empty stack";
        send_word(ism_pkg::CMD_MUL, $urandom());
      end
      2: begin
        fault_case = "duplicate on empty stack";
        send_word(ism_pkg::CMD_DUP, $urandom());
      end
      3: begin
        fault_case = "push onto full stack";
        fill_stack();
        send_word(ism_pkg::CMD_PUSH, pick_imm());
      end
      default: begin
        fault_case = "duplicate on full stack";
        fill_stack();
        send_word(ism_pkg::CMD_DUP, $urandom());
      end
    endcase
    send_word(ism_pkg::CMD_DUMP, $urandom());
    repeat (24) send_word(3'($urandom()), $urandom());

    // Let the refused dump and any stray result words come out
    drain();
    start <= 1'b0;
    repeat (DEPTH + 16) @(posedge clk);

    $display("summary: %0d words sent, %0d results checked, %0d dumps, deepest stack %0d",
             words_sent, sb.checked, dumps, deepest);
    $display("programs closed by dumps, with stall drains; closing error case: %s", fault_case);
    if (sb.pending() != 0)
      $display("%0d expected results never arrived", sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb OK");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/ism_pkg.sv
sv/ism_ctrl.sv
sv/ism_datapath.sv
sv/integer_stack_machine.sv
verif/tb.sv
